### hdl/spb_pkg.sv
// ----------------------------------------------------------------------------
// spb_pkg
// Shared types and codes for the skinning palette builder.
// ----------------------------------------------------------------------------
package spb_pkg;

  localparam int ELEM_W = 32;

  // item kinds
  localparam logic [2:0] KIND_INV_BIND = 3'd0;
  localparam logic [2:0] KIND_ROOT     = 3'd1;
  localparam logic [2:0] KIND_AUX      = 3'd2;
  localparam logic [2:0] KIND_NODE     = 3'd3;
  localparam logic [2:0] KIND_FRAME    = 3'd4;

  // configuration register indexes
  localparam logic REG_TREE_MODE  = 1'b0;
  localparam logic REG_BONE_COUNT = 1'b1;

  // operand source codes for the shared multiply-accumulate unit
  typedef enum logic [2:0] {
    SRC_ROOT  = 3'd0,
    SRC_AUX   = 3'd1,
    SRC_LOCAL = 3'd2,
    SRC_PARENT = 3'd3,
    SRC_WORK  = 3'd4,
    SRC_INV   = 3'd5,
    SRC_IDENT = 3'd6
  } src_t;

  // accumulator control from the sequencer
  typedef struct packed {
    logic clear;
    logic add;
  } mac_ctrl_t;

endpackage

### hdl/spb_mac.sv
// ----------------------------------------------------------------------------
// spb_mac
// Shared 32x32 multiplier with a split-fraction accumulator. One product
// per cycle; the rounded, saturated element is available after four terms.
// ----------------------------------------------------------------------------
module spb_mac #(
  parameter int FRAC_BITS = 16
) (
  input  logic                       clk,
  input  logic signed [31:0]         a,
  input  logic signed [31:0]         b,
  input  spb_pkg::mac_ctrl_t         ctrl,
  output logic signed [31:0]         result
);
  import spb_pkg::*;

  localparam int HI_W = 64 - FRAC_BITS + 3;

  logic signed [63:0]         prod;
  logic                       prod_add;
  logic                       prod_clear;
  logic signed [HI_W-1:0]     qs;
  logic        [FRAC_BITS+2:0] rs;
  logic signed [HI_W-1:0]     v;

  // stage 1: product register
  always_ff @(posedge clk) begin
    prod       <= 64'(a) * 64'(b);
    prod_add   <= ctrl.add;
    prod_clear <= ctrl.clear;
  end

  // stage 2: integer and fraction parts accumulate separately
  always_ff @(posedge clk) begin
    if (prod_clear) begin
      qs <= '0;
      rs <= '0;
    end else if (prod_add) begin
      qs <= qs + HI_W'(prod >>> FRAC_BITS);
      rs <= rs + (FRAC_BITS+3)'(prod[FRAC_BITS-1:0]);
    end
  end

  // round half up and saturate
  always_comb begin
    v = qs + HI_W'((rs + (FRAC_BITS+3)'(1 << (FRAC_BITS-1))) >> FRAC_BITS);
    if (v > HI_W'(64'sh7FFFFFFF))
      result = 32'sh7FFFFFFF;
    else if (v < -HI_W'(64'sh80000000))
      result = 32'sh80000000;
    else
      result = v[31:0];
  end

endmodule

### hdl/spb_mat_store.sv
// ----------------------------------------------------------------------------
// spb_mat_store
// Matrix memory, one 32-bit element per word, addressed by entry and
// element. One write and one registered read each cycle.
// ----------------------------------------------------------------------------
module spb_mat_store #(
  parameter int ENTRIES = 64
) (
  input  logic                             clk,
  input  logic                             we,
  input  logic [$clog2(ENTRIES*16)-1:0]    waddr,
  input  logic [31:0]                      wdata,
  input  logic [$clog2(ENTRIES*16)-1:0]    raddr,
  output logic [31:0]                      rdata
);
  import spb_pkg::*;

  logic [31:0] mem [ENTRIES*16];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### hdl/skinning_palette_builder.sv
// ----------------------------------------------------------------------------
// skinning_palette_builder
// Builds skinning palette matrices from a parent-first node stream using
// one shared Q16.16 multiply-accumulate unit under a small sequencer.
// ----------------------------------------------------------------------------
// channel   dir  handshake          payload
// in        in   in_valid/in_ready  kind, slots, column, flags, elem0..3
// out       out  out_valid/out_ready out_bone, out_column, out_elem0..3, last
// cfg       in   cfg_we             cfg_index, cfg_data
//
// Frame, root, unknown and node columns 0..2 finish in the load state; inverse
// bind and aux loads write one element per cycle. Column 3 of a node runs
// up to three 4x4 products on the one multiplier, 16 elements each, every
// element issued, drained and stored in turn, plus a global copy of 16
// elements. Results are held while out_ready is low.
// Reset clears marks, root matrix to identity and the local matrix.
// ----------------------------------------------------------------------------
module skinning_palette_builder #(
  parameter int MAX_NODES = 64,
  parameter int MAX_BONES = 64,
  parameter int FRAC_BITS = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic               cfg_index,
  input  logic [6:0]         cfg_data,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [2:0]         kind,
  input  logic [5:0]         node_slot,
  input  logic signed [6:0]  parent_slot,
  input  logic signed [6:0]  bone_slot,
  input  logic [1:0]         column_index,
  input  logic               has_animation,
  input  logic signed [31:0] elem0,
  input  logic signed [31:0] elem1,
  input  logic signed [31:0] elem2,
  input  logic signed [31:0] elem3,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [5:0]         out_bone,
  output logic [1:0]         out_column,
  output logic signed [31:0] out_elem0,
  output logic signed [31:0] out_elem1,
  output logic signed [31:0] out_elem2,
  output logic signed [31:0] out_elem3,
  output logic               last_column
);
  import spb_pkg::*;

  localparam int NA = $clog2(MAX_NODES*16);
  localparam int BA = $clog2(MAX_BONES*16);
  localparam int NI = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;

  typedef enum logic [8:0] {
    S_IDLE  = 9'b000000001,
    S_LOAD  = 9'b000000010,
    S_PLAN  = 9'b000000100,
    S_ISSUE = 9'b000001000,
    S_WAIT  = 9'b000010000,
    S_STORE = 9'b000100000,
    S_NEXT  = 9'b001000000,
    S_EMIT  = 9'b010000000,
    S_COPY  = 9'b100000000
  } state_t;

  // product step codes
  typedef enum logic [1:0] {
    P_PRE  = 2'd0,
    P_GLOB = 2'd1,
    P_PAL  = 2'd2
  } step_t;

  state_t state;
  step_t  step;

  logic              tree_mode;
  logic [6:0]        bone_count;
  logic [MAX_NODES-1:0] marks;

  // captured item
  logic [2:0]  i_kind;
  logic [5:0]  i_node;
  logic signed [6:0] i_parent;
  logic signed [6:0] i_bone;
  logic [1:0]  i_col;
  logic        i_anim;
  logic [31:0] i_e [4];

  // small matrices in flip-flops: [column*4+row]
  logic [31:0] root_m  [16];
  logic [31:0] local_m [16];
  logic [31:0] work_m  [16];
  logic [31:0] res_m   [16];

  // loop counters: element (c,r) and term k
  logic [3:0] elem_idx;
  logic [2:0] k_cnt;
  logic [2:0] wait_cnt;
  logic [1:0] emit_col;
  logic [3:0] copy_idx;

  logic node_ok, bone_ld_ok, parent_ok, emit_ok, glob_skip;
  src_t src_a, src_b;

  assign node_ok    = 32'(i_node) < MAX_NODES;
  assign bone_ld_ok = !i_bone[6] && 32'(i_bone) < MAX_BONES;
  assign parent_ok  = !i_parent[6] && 32'(i_parent) < MAX_NODES
                      && marks[NI'(i_parent)];
  assign emit_ok    = !i_bone[6] && i_bone < $signed({1'b0, bone_count})
                      && 32'(i_bone) < MAX_BONES;
  // global equals the working matrix: tree-mode root, or a parent out of range or not written this frame
  assign glob_skip  = i_parent[6] ? tree_mode : !parent_ok;

  // memories
  logic          g_we, ib_we, ax_we;
  logic [NA-1:0] g_waddr, g_raddr, ax_waddr, ax_raddr;
  logic [BA-1:0] ib_waddr, ib_raddr;
  logic [31:0]   g_wdata, ib_wdata, ax_wdata;
  logic [31:0]   g_rdata, ib_rdata, ax_rdata;

  spb_mat_store #(.ENTRIES(MAX_NODES)) u_global (
    .clk(clk), .we(g_we), .waddr(g_waddr), .wdata(g_wdata),
    .raddr(g_raddr), .rdata(g_rdata));
  spb_mat_store #(.ENTRIES(MAX_BONES)) u_inv (
    .clk(clk), .we(ib_we), .waddr(ib_waddr), .wdata(ib_wdata),
    .raddr(ib_raddr), .rdata(ib_rdata));
  spb_mat_store #(.ENTRIES(MAX_NODES)) u_aux (
    .clk(clk), .we(ax_we), .waddr(ax_waddr), .wdata(ax_wdata),
    .raddr(ax_raddr), .rdata(ax_rdata));

  // operand indexes: a is element (row=r, col=k), b is element (row=k, col=c)
  logic [1:0] cur_c, cur_r, kk;
  logic [3:0] a_idx, b_idx;
  assign cur_c = elem_idx[3:2];
  assign cur_r = elem_idx[1:0];
  assign kk    = k_cnt[1:0];
  assign a_idx = {kk, cur_r};
  assign b_idx = {cur_c, kk};

  // per step operand sources; tree-mode default runs aux times identity
  always_comb begin
    src_a = SRC_AUX;
    src_b = SRC_LOCAL;
    case (step)
      P_PRE: begin
        src_a = SRC_AUX;
        src_b = tree_mode ? SRC_IDENT : SRC_LOCAL;
      end
      P_GLOB: begin
        src_a = i_parent[6] ? SRC_ROOT : SRC_PARENT;
        src_b = SRC_WORK;
      end
      P_PAL: begin
        src_a = SRC_WORK;
        src_b = SRC_INV;
      end
      default: ;
    endcase
  end

  // memory read addresses track the issue counters
  assign g_raddr  = NA'({NI'(i_parent), a_idx});
  assign ax_raddr = NA'({NI'(i_node), a_idx});
  assign ib_raddr = BA'({i_bone[5:0], b_idx});

  // operands are aligned in the cycle after the address
  logic [3:0]  a_idx_d, b_idx_d;
  logic        issue_d;
  src_t        src_a_d, src_b_d;
  logic signed [31:0] op_a, op_b;
  mac_ctrl_t   ctrl;
  logic signed [31:0] mac_out;

  always_ff @(posedge clk) begin
    a_idx_d <= a_idx;
    b_idx_d <= b_idx;
    src_a_d <= src_a;
    src_b_d <= src_b;
    issue_d <= (state == S_ISSUE) && !k_cnt[2];
  end

  always_comb begin
    case (src_a_d)
      SRC_ROOT:   op_a = root_m[a_idx_d];
      SRC_AUX:    op_a = node_ok ? ax_rdata : '0;
      SRC_PARENT: op_a = g_rdata;
      SRC_WORK:   op_a = work_m[a_idx_d];
      default:    op_a = '0;
    endcase
    case (src_b_d)
      SRC_LOCAL: op_b = local_m[b_idx_d];
      SRC_WORK:  op_b = work_m[b_idx_d];
      SRC_INV:   op_b = ib_rdata;
      SRC_IDENT: op_b = (b_idx_d[3:2] == b_idx_d[1:0]) ? 32'(1 << FRAC_BITS) : '0;
      default:   op_b = '0;
    endcase
  end

  assign ctrl.clear = (state == S_ISSUE) && (k_cnt == 3'd0) && !issue_d;
  assign ctrl.add   = issue_d;

  spb_mac #(.FRAC_BITS(FRAC_BITS)) u_mac (
    .clk(clk), .a(op_a), .b(op_b), .ctrl(ctrl), .result(mac_out));

  // store writes
  always_comb begin
    ib_we    = (state == S_LOAD) && (i_kind == KIND_INV_BIND) && bone_ld_ok;
    ib_waddr = BA'({i_bone[5:0], i_col, copy_idx[1:0]});
    ib_wdata = i_e[copy_idx[1:0]];
    ax_we    = (state == S_LOAD) && (i_kind == KIND_AUX) && node_ok;
    ax_waddr = NA'({NI'(i_node), i_col, copy_idx[1:0]});
    ax_wdata = i_e[copy_idx[1:0]];
    g_we     = (state == S_COPY) && node_ok;
    g_waddr  = NA'({NI'(i_node), copy_idx});
    g_wdata  = work_m[copy_idx];
  end

  // configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      tree_mode  <= 1'b0;
      bone_count <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_TREE_MODE:  tree_mode  <= cfg_data[0];
        REG_BONE_COUNT: bone_count <= cfg_data;
        default: ;
      endcase
    end
  end

  assign in_ready = (state == S_IDLE);

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      step     <= P_PRE;
      marks    <= '0;
      out_valid <= 1'b0;
      elem_idx <= '0;
      k_cnt    <= '0;
      wait_cnt <= '0;
      emit_col <= '0;
      copy_idx <= '0;
      for (int i = 0; i < 16; i++) begin
        root_m[i]  <= (i % 5 == 0) ? 32'(1 << FRAC_BITS) : '0;
        local_m[i] <= '0;
      end
    end else begin
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            i_kind   <= kind;
            i_node   <= node_slot;
            i_parent <= parent_slot;
            i_bone   <= bone_slot;
            i_col    <= column_index;
            i_anim   <= has_animation;
            i_e[0]   <= elem0;
            i_e[1]   <= elem1;
            i_e[2]   <= elem2;
            i_e[3]   <= elem3;
            copy_idx <= '0;
            state    <= S_LOAD;
          end
        end
        // inverse bind and aux loads write one element per cycle into memories
        S_LOAD: begin
          case (i_kind)
            KIND_FRAME: begin
              marks <= '0;
              state <= S_IDLE;
            end
            KIND_ROOT: begin
              for (int r = 0; r < 4; r++) root_m[{i_col, 2'(r)}] <= i_e[r];
              state <= S_IDLE;
            end
            KIND_NODE: begin
              for (int r = 0; r < 4; r++) local_m[{i_col, 2'(r)}] <= i_e[r];
              state <= (i_col == 2'd3) ? S_PLAN : S_IDLE;
            end
            KIND_INV_BIND, KIND_AUX: begin
              copy_idx <= copy_idx + 4'd1;
              if (copy_idx == 4'd3) state <= S_IDLE;
            end
            default: state <= S_IDLE;
          endcase
        end
        // choose local and first product
        S_PLAN: begin
          elem_idx <= '0;
          k_cnt    <= '0;
          copy_idx <= '0;
          if (tree_mode && i_anim) begin
            for (int i = 0; i < 16; i++) work_m[i] <= local_m[i];
            step  <= P_GLOB;
            state <= glob_skip ? S_COPY : S_ISSUE;
          end else begin
            // pre-transform product, or aux brought in through the read port
            step  <= P_PRE;
            state <= S_ISSUE;
          end
        end
        // four terms of one element, then drain
        S_ISSUE: begin
          if (!k_cnt[2]) begin
            k_cnt <= k_cnt + 3'd1;
          end else begin
            wait_cnt <= '0;
            state    <= S_WAIT;
          end
        end
        S_WAIT: begin
          wait_cnt <= wait_cnt + 3'd1;
          if (wait_cnt == 3'd1) state <= S_STORE;
        end
        S_STORE: begin
          res_m[elem_idx] <= mac_out;
          k_cnt <= '0;
          if (elem_idx == 4'd15) begin
            state <= S_NEXT;
          end else begin
            elem_idx <= elem_idx + 4'd1;
            state    <= S_ISSUE;
          end
        end
        // decide what follows a finished product
        S_NEXT: begin
          elem_idx <= '0;
          k_cnt    <= '0;
          copy_idx <= '0;
          case (step)
            P_PRE: begin
              for (int i = 0; i < 16; i++) work_m[i] <= res_m[i];
              step  <= P_GLOB;
              state <= glob_skip ? S_COPY : S_ISSUE;
            end
            P_GLOB: begin
              for (int i = 0; i < 16; i++) work_m[i] <= res_m[i];
              state <= S_COPY;
            end
            P_PAL: begin
              emit_col  <= '0;
              out_valid <= 1'b1;
              state     <= S_EMIT;
            end
            default: state <= S_IDLE;
          endcase
        end
        // keep global, then go on to the palette product if the bone is emitted
        S_COPY: begin
          copy_idx <= copy_idx + 4'd1;
          if (copy_idx == 4'd15) begin
            if (node_ok) marks[NI'(i_node)] <= 1'b1;
            if (emit_ok) begin
              step     <= P_PAL;
              elem_idx <= '0;
              k_cnt    <= '0;
              state    <= S_ISSUE;
            end else begin
              state <= S_IDLE;
            end
          end
        end
        S_EMIT: begin
          if (out_ready) begin
            emit_col <= emit_col + 2'd1;
            if (emit_col == 2'd3) begin
              out_valid <= 1'b0;
              state     <= S_IDLE;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign out_bone    = i_bone[5:0];
  assign out_column  = emit_col;
  assign out_elem0   = res_m[{emit_col, 2'd0}];
  assign out_elem1   = res_m[{emit_col, 2'd1}];
  assign out_elem2   = res_m[{emit_col, 2'd2}];
  assign out_elem3   = res_m[{emit_col, 2'd3}];
  assign last_column = (emit_col == 2'd3);

  // checks
  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !in_ready) else $error("input taken while emitting");
  a_emit_state: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> state == S_EMIT) else $error("result shown outside emit");
  a_col_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> $stable(emit_col)) else $error("column moved");

endmodule
